// ===== hw/rtl/wavu8_pkg.sv =====
// Shared types, codes and constants of the WAV byte-stream parser.
package wavu8_pkg;

  localparam int RATE_W = 18;

  localparam logic [RATE_W-1:0] RATE_FLOOR_RST   = 18'd4000;
  localparam logic [RATE_W-1:0] RATE_CEILING_RST = 18'd23000;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_RATE   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [2:0] ERR_NOT_WAVE  = 3'd0;
  localparam logic [2:0] ERR_EOF_EARLY = 3'd1;
  localparam logic [2:0] ERR_BAD_FMT   = 3'd2;
  localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
  localparam logic [2:0] ERR_NO_FMT    = 3'd4;
  localparam logic [2:0] ERR_BAD_CHAN  = 3'd5;
  localparam logic [2:0] ERR_BAD_WIDTH = 3'd6;

  // Register indexes on the configuration port
  localparam logic REG_RATE_FLOOR   = 1'b0;
  localparam logic REG_RATE_CEILING = 1'b1;

  // Result queue
  localparam int Q_AW    = 2;
  localparam int Q_DEPTH = 1 << Q_AW;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_CHUNK  = 6'b000010,
    PH_FMT    = 6'b000100,
    PH_SKIP   = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_HALT   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        sample;
    logic [RATE_W-1:0] rate;
    logic [2:0]        err;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  function automatic res_t make_res(logic [1:0] k, logic [7:0] s,
                                    logic [RATE_W-1:0] r, logic [2:0] e);
    res_t x;
    x.kind   = k;
    x.sample = s;
    x.rate   = r;
    x.err    = e;
    x.last   = 1'b0;
    return x;
  endfunction

endpackage

// ===== hw/rtl/wavu8_parser.sv =====
// RIFF/WAVE chunk walker and mono mixdown: parse state and per-byte results.
module wavu8_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [7:0]                    file_byte,
  input  logic                          start_of_file,
  input  logic                          end_of_file,
  input  logic [wavu8_pkg::RATE_W-1:0]  rate_floor,
  input  logic [wavu8_pkg::RATE_W-1:0]  rate_ceiling,
  output wavu8_pkg::res_pair_t          res
);

  wavu8_pkg::phase_t phase, phase_c, phase_next;
  logic [4:0]  cnt, cnt_c, cnt_next;
  logic [31:0] tag, tag_c, tag_next;
  logic [31:0] len, len_c, len_next;
  logic [32:0] skip, skip_c, skip_next;
  logic [15:0] ftag, ftag_c, ftag_next;
  logic [15:0] chan, chan_c, chan_next;
  logic [31:0] frate, frate_c, frate_next;
  logic [15:0] bits, bits_c, bits_next;
  logic        seen, seen_c, seen_next;
  logic [31:0] left, left_c, left_next;
  logic [1:0]  fbi, fbi_c, fbi_next;
  logic signed [9:0] sum, sum_c, sum_next;

  logic [2:0]  fb;
  logic [31:0] speed;
  logic [32:0] skip_dec;
  logic signed [9:0] s10, rnd, acc;
  logic [7:0]  smp;
  logic [1:0]  n;
  wavu8_pkg::res_t slot [2];

  always_comb begin
    // restart all parse state on a start-of-file byte
    phase_c = start_of_file ? wavu8_pkg::PH_HEADER : phase;
    cnt_c   = start_of_file ? 5'd0  : cnt;
    tag_c   = start_of_file ? 32'd0 : tag;
    len_c   = start_of_file ? 32'd0 : len;
    skip_c  = start_of_file ? 33'd0 : skip;
    ftag_c  = start_of_file ? 16'd0 : ftag;
    chan_c  = start_of_file ? 16'd0 : chan;
    frate_c = start_of_file ? 32'd0 : frate;
    bits_c  = start_of_file ? 16'd0 : bits;
    seen_c  = start_of_file ? 1'b0  : seen;
    left_c  = start_of_file ? 32'd0 : left;
    fbi_c   = start_of_file ? 2'd0  : fbi;
    sum_c   = start_of_file ? 10'sd0 : sum;

    phase_next = phase_c;
    cnt_next   = cnt_c;
    tag_next   = tag_c;
    len_next   = len_c;
    skip_next  = skip_c;
    ftag_next  = ftag_c;
    chan_next  = chan_c;
    frate_next = frate_c;
    bits_next  = bits_c;
    seen_next  = seen_c;
    left_next  = left_c;
    fbi_next   = fbi_c;
    sum_next   = sum_c;

    n       = 2'd0;
    slot[0] = '0;
    slot[1] = '0;

    // bytes per frame, meaningful once channels and width have been checked
    fb = (bits_c == 16'd16) ? {chan_c[1:0], 1'b0} : {1'b0, chan_c[1:0]};

    speed = frate_c;
    if (speed < {14'd0, rate_floor}) speed = {14'd0, rate_floor};
    if (speed > {14'd0, rate_ceiling}) speed = {14'd0, rate_ceiling};

    skip_dec = (skip_c != 33'd0) ? skip_c - 33'd1 : skip_c;

    s10 = sum_c;
    if (bits_c == 16'd8) begin
      s10 = sum_c + $signed({2'b00, file_byte}) - 10'sd128;
    end else if (fbi_c[0]) begin
      s10 = sum_c + $signed({{2{file_byte[7]}}, file_byte});
    end
    // halve with truncation toward zero for stereo
    rnd = s10 + $signed({9'd0, s10[9]});
    acc = chan_c[1] ? (rnd >>> 1) : s10;
    if (acc > 10'sd127) smp = 8'd255;
    else if (acc < -10'sd128) smp = 8'd0;
    else smp = {~acc[7], acc[6:0]};

    case (phase_c)
      wavu8_pkg::PH_HEADER: begin
        if (cnt_c < 5'd4 || cnt_c >= 5'd8) tag_next = {file_byte, tag_c[31:8]};
        if (cnt_c == 5'd3) len_next = (tag_next == wavu8_pkg::TAG_RIFF) ? 32'd1 : 32'd0;
        if (cnt_c >= 5'd11) begin
          if (len_next == 32'd1 && tag_next == wavu8_pkg::TAG_WAVE) begin
            phase_next = wavu8_pkg::PH_CHUNK;
            cnt_next   = 5'd0;
          end else begin
            slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_ERROR, 8'd0, '0,
                                             wavu8_pkg::ERR_NOT_WAVE);
            n = n + 2'd1;
            phase_next = wavu8_pkg::PH_HALT;
          end
        end else begin
          cnt_next = cnt_c + 5'd1;
        end
      end
      wavu8_pkg::PH_CHUNK: begin
        if (cnt_c < 5'd4) tag_next = {file_byte, tag_c[31:8]};
        else len_next = {file_byte, len_c[31:8]};
        if (cnt_c >= 5'd7) begin
          if (tag_next == wavu8_pkg::TAG_FMT) begin
            if (len_next < 32'd16) begin
              slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_ERROR, 8'd0, '0,
                                               wavu8_pkg::ERR_BAD_FMT);
              n = n + 2'd1;
              phase_next = wavu8_pkg::PH_HALT;
            end else begin
              phase_next = wavu8_pkg::PH_FMT;
              cnt_next   = 5'd0;
            end
          end else if (tag_next == wavu8_pkg::TAG_DATA) begin
            if (!seen_c) begin
              slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_ERROR, 8'd0, '0,
                                               wavu8_pkg::ERR_NO_FMT);
              n = n + 2'd1;
              phase_next = wavu8_pkg::PH_HALT;
            end else if (chan_c != 16'd1 && chan_c != 16'd2) begin
              slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_ERROR, 8'd0, '0,
                                               wavu8_pkg::ERR_BAD_CHAN);
              n = n + 2'd1;
              phase_next = wavu8_pkg::PH_HALT;
            end else if (bits_c != 16'd8 && bits_c != 16'd16) begin
              slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_ERROR, 8'd0, '0,
                                               wavu8_pkg::ERR_BAD_WIDTH);
              n = n + 2'd1;
              phase_next = wavu8_pkg::PH_HALT;
            end else begin
              slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_RATE, 8'd0,
                                               speed[wavu8_pkg::RATE_W-1:0], '0);
              n = n + 2'd1;
              left_next = len_next;
              fbi_next  = 2'd0;
              sum_next  = 10'sd0;
              if (len_next < {29'd0, fb}) begin
                slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_DONE, 8'd0, '0, '0);
                n = n + 2'd1;
                phase_next = wavu8_pkg::PH_HALT;
              end else begin
                phase_next = wavu8_pkg::PH_DATA;
              end
            end
          end else begin
            // other chunk: skip its body and any pad byte
            skip_next = {1'b0, len_next} + {32'd0, len_next[0]};
            if (skip_next != 33'd0) begin
              phase_next = wavu8_pkg::PH_SKIP;
            end else begin
              phase_next = wavu8_pkg::PH_CHUNK;
              cnt_next   = 5'd0;
            end
          end
        end else begin
          cnt_next = cnt_c + 5'd1;
        end
      end
      wavu8_pkg::PH_FMT: begin
        if (cnt_c < 5'd2) ftag_next = {file_byte, ftag_c[15:8]};
        else if (cnt_c < 5'd4) chan_next = {file_byte, chan_c[15:8]};
        else if (cnt_c < 5'd8) frate_next = {file_byte, frate_c[31:8]};
        else if (cnt_c >= 5'd14) bits_next = {file_byte, bits_c[15:8]};
        if (cnt_c >= 5'd15) begin
          if (ftag_next != 16'd1) begin
            slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_ERROR, 8'd0, '0,
                                             wavu8_pkg::ERR_NOT_PCM);
            n = n + 2'd1;
            phase_next = wavu8_pkg::PH_HALT;
          end else begin
            seen_next = 1'b1;
            // extra fmt bytes plus pad
            skip_next = {1'b0, len_c - 32'd16} + {32'd0, len_c[0]};
            if (skip_next != 33'd0) begin
              phase_next = wavu8_pkg::PH_SKIP;
            end else begin
              phase_next = wavu8_pkg::PH_CHUNK;
              cnt_next   = 5'd0;
            end
          end
        end else begin
          cnt_next = cnt_c + 5'd1;
        end
      end
      wavu8_pkg::PH_SKIP: begin
        skip_next = skip_dec;
        if (skip_dec == 33'd0) begin
          phase_next = wavu8_pkg::PH_CHUNK;
          cnt_next   = 5'd0;
        end
      end
      wavu8_pkg::PH_DATA: begin
        left_next = left_c - 32'd1;
        if ({1'b0, fbi_c} + 3'd1 >= fb) begin
          slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_SAMPLE, smp, '0, '0);
          n = n + 2'd1;
          fbi_next = 2'd0;
          sum_next = 10'sd0;
          if (left_next < {29'd0, fb}) begin
            slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_DONE, 8'd0, '0, '0);
            n = n + 2'd1;
            phase_next = wavu8_pkg::PH_HALT;
          end
        end else begin
          fbi_next = fbi_c + 2'd1;
          sum_next = s10;
        end
      end
      default: begin
      end
    endcase

    if (end_of_file) begin
      case (phase_next)
        wavu8_pkg::PH_HEADER: begin
          slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_ERROR, 8'd0, '0,
                                           wavu8_pkg::ERR_NOT_WAVE);
          n = n + 2'd1;
          phase_next = wavu8_pkg::PH_HALT;
        end
        wavu8_pkg::PH_CHUNK, wavu8_pkg::PH_SKIP: begin
          slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_ERROR, 8'd0, '0,
                                           wavu8_pkg::ERR_EOF_EARLY);
          n = n + 2'd1;
          phase_next = wavu8_pkg::PH_HALT;
        end
        wavu8_pkg::PH_FMT: begin
          slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_ERROR, 8'd0, '0,
                                           wavu8_pkg::ERR_BAD_FMT);
          n = n + 2'd1;
          phase_next = wavu8_pkg::PH_HALT;
        end
        wavu8_pkg::PH_DATA: begin
          slot[n[0]] = wavu8_pkg::make_res(wavu8_pkg::KIND_DONE, 8'd0, '0, '0);
          n = n + 2'd1;
          phase_next = wavu8_pkg::PH_HALT;
        end
        default: begin
        end
      endcase
    end

    // mark the final result of this byte
    if (n == 2'd1) slot[0].last = 1'b1;
    if (n == 2'd2) slot[1].last = 1'b1;

    res.n  = n;
    res.r0 = slot[0];
    res.r1 = slot[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wavu8_pkg::PH_HEADER;
      cnt   <= 5'd0;
      tag   <= 32'd0;
      len   <= 32'd0;
      skip  <= 33'd0;
      ftag  <= 16'd0;
      chan  <= 16'd0;
      frate <= 32'd0;
      bits  <= 16'd0;
      seen  <= 1'b0;
      left  <= 32'd0;
      fbi   <= 2'd0;
      sum   <= 10'sd0;
    end else if (take) begin
      phase <= phase_next;
      cnt   <= cnt_next;
      tag   <= tag_next;
      len   <= len_next;
      skip  <= skip_next;
      ftag  <= ftag_next;
      chan  <= chan_next;
      frate <= frate_next;
      bits  <= bits_next;
      seen  <= seen_next;
      left  <= left_next;
      fbi   <= fbi_next;
      sum   <= sum_next;
    end
  end

endmodule

// ===== hw/rtl/wav_stream_to_u8_mono_top.sv =====
// Top level: WAV byte-stream parser with APB rate limits and a result queue.
//
// Takes one WAV file byte per cycle and turns it into results: the clamped
// playback rate when the data chunk is reached, one unsigned 8-bit mono
// sample per whole frame, an error code, or a playback-finished mark. Each
// byte is parsed in the cycle it is accepted and its zero, one or two results
// enter a four-entry result queue; the queue drains one result per cycle
// while out_ready is high. in_ready is high while the queue has room for two
// results, so a byte is accepted every cycle as long as results are taken at
// least as fast as they are produced; a byte that yields two results (rate and
// finish, or sample and finish) fills two queue entries. rate_floor sits at byte
// address 0 and rate_ceiling at 4; write them only while the block is idle.
module wav_stream_to_u8_mono_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    file_byte,
  input  logic                          start_of_file,
  input  logic                          end_of_file,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    result_kind,
  output logic [7:0]                    sample_out,
  output logic [wavu8_pkg::RATE_W-1:0]  rate_out,
  output logic [2:0]                    error_code,
  output logic                          last_of_run
);

  logic [wavu8_pkg::RATE_W-1:0] rate_floor, rate_ceiling;
  logic                         cfg_wr;

  logic                         take, pop;
  wavu8_pkg::res_pair_t         res;
  wavu8_pkg::res_t              q [wavu8_pkg::Q_DEPTH];
  logic [wavu8_pkg::Q_AW-1:0]   head, tail;
  logic [wavu8_pkg::Q_AW:0]     count;
  wavu8_pkg::res_t              q_head;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[2])
      wavu8_pkg::REG_RATE_FLOOR:   prdata = {14'd0, rate_floor};
      wavu8_pkg::REG_RATE_CEILING: prdata = {14'd0, rate_ceiling};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_floor   <= wavu8_pkg::RATE_FLOOR_RST;
      rate_ceiling <= wavu8_pkg::RATE_CEILING_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == wavu8_pkg::REG_RATE_FLOOR) begin
        rate_floor <= pwdata[wavu8_pkg::RATE_W-1:0];
      end else begin
        rate_ceiling <= pwdata[wavu8_pkg::RATE_W-1:0];
      end
    end
  end

  // parser
  assign in_ready = (count <= (wavu8_pkg::Q_AW+1)'(wavu8_pkg::Q_DEPTH - 2));
  assign take     = in_valid & in_ready;

  wavu8_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .file_byte     (file_byte),
    .start_of_file (start_of_file),
    .end_of_file   (end_of_file),
    .rate_floor    (rate_floor),
    .rate_ceiling  (rate_ceiling),
    .res           (res)
  );

  // result queue
  assign out_valid = (count != '0);
  assign pop       = out_valid & out_ready;
  assign q_head    = q[head];

  assign result_kind = q_head.kind;
  assign sample_out  = q_head.sample;
  assign rate_out    = q_head.rate;
  assign error_code  = q_head.err;
  assign last_of_run = q_head.last;

  always_ff @(posedge clk) begin
    if (take) begin
      if (res.n != 2'd0) q[tail] <= res.r0;
      if (res.n == 2'd2) q[tail + 1'b1] <= res.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (take) tail <= tail + res.n[wavu8_pkg::Q_AW-1:0];
      if (pop) head <= head + 1'b1;
      count <= count + (take ? {1'b0, res.n} : '0) - {{wavu8_pkg::Q_AW{1'b0}}, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (wavu8_pkg::Q_AW+1)'(wavu8_pkg::Q_DEPTH))
    else $error("result queue overfilled");

  a_two_max: assert property (@(posedge clk) disable iff (rst)
    take |-> res.n != 2'd3)
    else $error("parser produced more than two results for one item");

  a_rate_only_on_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != wavu8_pkg::KIND_RATE |-> rate_out == '0)
    else $error("rate field set on a non-rate result");

  a_floor_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr && paddr[2] == wavu8_pkg::REG_RATE_FLOOR
    |=> rate_floor == $past(pwdata[wavu8_pkg::RATE_W-1:0]))
    else $error("rate floor write lost");
`endif

endmodule
